### hdl/shtab_pkg.sv
`timescale 1ns / 1ps

package shtab_pkg;

  // Default sizing
  localparam int unsigned DefTableDepth  = 1024;
  localparam int unsigned DefElementBits = 64;

  // Fixed field widths
  localparam int unsigned HashW    = 64;
  localparam int unsigned SizeW    = 11;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned CharW    = 8;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned BitCntW  = 6;
  localparam int unsigned QueueDepth = 2;

  // Hash multiplier (97 = 64 + 32 + 1)
  localparam int unsigned HashMult = 97;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTableSize   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPointerMode = 2'd1;

  localparam logic [SizeW-1:0] TableSizeReset = 11'd1024;

  typedef enum logic [1:0] {
    MODE_SET  = 2'd0,
    MODE_GET  = 2'd1,
    MODE_FILL = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_WRONG_KIND = 2'd1,
    STATUS_EMPTY      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_SET  = 2'd0,
    JOB_GET  = 2'd1,
    JOB_FILL = 2'd2
  } job_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_FILL,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CharW-1:0]  name_char;
    logic              name_last;
    logic [ValueW-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ValueW-1:0] read_value;
    logic [SlotW-1:0]  slot;
  } out_item_t;

  // Work handed from front to back
  typedef struct packed {
    job_e              kind;
    logic [HashW-1:0]  hash;
    logic [ValueW-1:0] wval;
  } job_t;

  // Queue handshake toward the back
  typedef struct packed {
    logic valid;
    job_t job;
  } job_port_t;

endpackage

### hdl/string_hashed_slot_table_core.sv
`timescale 1ns / 1ps

// String-hashed slot table. Name characters arrive one per item and fold into
// a 64-bit hash (hash * 97 + char); the item marked last ends the name, and a
// set or get then acts on slot hash mod table_size. Fill writes one value to
// every slot in use. A character that does not end a name only updates the
// hash in the front and yields no result. A name end or a fill goes through a
// two-entry queue to the back: a set or get runs the bit-serial 64-step modulo
// unit; a fill writes the clamped table size of slots (table_size held to
// 1..TABLE_DEPTH), one memory write per slot, and nothing in pointer mode.
// After reset the back clears all TABLE_DEPTH slots (1024 by default), one
// slot per cycle; input is stalled during that pass while configuration
// writes are taken. Results leave through an output register, so the back
// moves on while a result waits to be taken.
module string_hashed_slot_table_core #(
  parameter int unsigned TABLE_DEPTH  = shtab_pkg::DefTableDepth,
  parameter int unsigned ELEMENT_BITS = shtab_pkg::DefElementBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  shtab_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output shtab_pkg::out_item_t          out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shtab_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [shtab_pkg::SizeW-1:0]   cfg_data_i
);
  import shtab_pkg::*;

  logic [SizeW-1:0] table_size_q;
  logic             pointer_mode_q;
  logic             push, pop, full, clear_busy;
  job_t             push_job;
  job_port_t        head;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q   <= TableSizeReset;
      pointer_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgTableSize) begin
        table_size_q <= cfg_data_i;
      end else if (cfg_index_i == CfgPointerMode) begin
        pointer_mode_q <= cfg_data_i[0];
      end
    end
  end

  shtab_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .clear_busy_i (clear_busy),
    .queue_full_i (full),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  shtab_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head)
  );

  shtab_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_size_i   (table_size_q),
    .pointer_mode_i (pointer_mode_q),
    .head_i         (head),
    .pop_o          (pop),
    .clear_busy_o   (clear_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

### hdl/shtab_front.sv
`timescale 1ns / 1ps

module shtab_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  shtab_pkg::in_item_t in_data_i,
  input  logic               clear_busy_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output shtab_pkg::job_t    push_job_o
);
  import shtab_pkg::*;

  logic [HashW-1:0] hash_q, hash_d, hash_next;
  logic             accept;

  // Hold items back while the table clears or the queue is full
  assign in_stall_o = clear_busy_i || queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Fold one character: hash * 97 + char
  assign hash_next = (hash_q << 6) + (hash_q << 5) + hash_q
                   + HashW'(in_data_i.name_char);

  // Classify the item and build the job
  always_comb begin
    hash_d           = hash_q;
    push_o           = 1'b0;
    push_job_o.kind  = JOB_SET;
    push_job_o.hash  = hash_next;
    push_job_o.wval  = in_data_i.write_value;
    if (accept) begin
      unique case (mode_e'(in_data_i.mode))
        MODE_SET, MODE_GET: begin
          if (in_data_i.name_last) begin
            push_o          = 1'b1;
            push_job_o.kind = (mode_e'(in_data_i.mode) == MODE_GET) ? JOB_GET : JOB_SET;
            hash_d          = '0;
          end else begin
            hash_d = hash_next;
          end
        end
        MODE_FILL: begin
          push_o          = 1'b1;
          push_job_o.kind = JOB_FILL;
        end
        MODE_NONE: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

### hdl/shtab_fifo.sv
`timescale 1ns / 1ps

module shtab_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  shtab_pkg::job_t      push_job_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output shtab_pkg::job_port_t head_o
);
  import shtab_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t                  store_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]         count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == (PtrW+1)'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = store_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### hdl/shtab_back.sv
`timescale 1ns / 1ps

module shtab_back #(
  parameter int unsigned TABLE_DEPTH  = shtab_pkg::DefTableDepth,
  parameter int unsigned ELEMENT_BITS = shtab_pkg::DefElementBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [shtab_pkg::SizeW-1:0]   table_size_i,
  input  logic                          pointer_mode_i,
  input  shtab_pkg::job_port_t          head_i,
  output logic                          pop_o,
  output logic                          clear_busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output shtab_pkg::out_item_t          out_data_o
);
  import shtab_pkg::*;

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CmpW  = (AddrW > SizeW) ? AddrW : SizeW;

  back_state_e             state_q, state_d;
  logic [AddrW-1:0]        cnt_q, cnt_d;
  logic [SizeW-1:0]        rem_q, rem_d;
  logic [HashW-1:0]        dvd_q, dvd_d;
  logic [BitCntW-1:0]      bit_q, bit_d;
  job_e                    kind_q, kind_d;
  logic [ELEMENT_BITS-1:0] wval_q, wval_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_data_q, out_data_d;

  logic [ELEMENT_BITS-1:0] mem_q [TABLE_DEPTH];
  logic [ELEMENT_BITS-1:0] rdata_q;
  logic                    we, re;
  logic [AddrW-1:0]        waddr;
  logic [ELEMENT_BITS-1:0] wdata;

  logic [SizeW-1:0]        eff_size;
  logic [SizeW:0]          trial;
  logic                    can_emit;

  // Clamp the configured size to 1..TABLE_DEPTH
  always_comb begin
    if (table_size_i == '0) begin
      eff_size = SizeW'(1);
    end else if (32'(table_size_i) > TABLE_DEPTH) begin
      eff_size = SizeW'(TABLE_DEPTH);
    end else begin
      eff_size = table_size_i;
    end
  end

  assign trial        = {rem_q, dvd_q[HashW-1]};
  assign can_emit     = !out_valid_q || !out_stall_i;
  assign clear_busy_o = (state_q == BK_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;

  // Sequencer: clear pass, bit-serial modulo, table access, result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    bit_d       = bit_q;
    kind_d      = kind_q;
    wval_d      = wval_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = cnt_q;
    wdata       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      BK_CLEAR: begin
        we = 1'b1;
        if (cnt_q == AddrW'(TABLE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = BK_IDLE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      BK_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          kind_d = head_i.job.kind;
          wval_d = ELEMENT_BITS'(head_i.job.wval);
          dvd_d  = head_i.job.hash;
          rem_d  = '0;
          bit_d  = '0;
          cnt_d  = '0;
          if (head_i.job.kind == JOB_FILL) begin
            state_d = pointer_mode_i ? BK_EMIT : BK_FILL;
          end else begin
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        // One quotient bit per cycle, remainder stays below the size
        if (trial >= {1'b0, eff_size}) begin
          rem_d = SizeW'(trial - {1'b0, eff_size});
        end else begin
          rem_d = SizeW'(trial);
        end
        dvd_d = dvd_q << 1;
        bit_d = bit_q + BitCntW'(1);
        if (bit_q == BitCntW'(HashW - 1)) begin
          state_d = (kind_q == JOB_GET) ? BK_READ : BK_EMIT;
        end
      end
      BK_READ: begin
        re      = 1'b1;
        state_d = BK_EMIT;
      end
      BK_FILL: begin
        we    = 1'b1;
        wdata = wval_q;
        if (CmpW'(cnt_q) == CmpW'(eff_size - SizeW'(1))) begin
          state_d = BK_EMIT;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      BK_EMIT: begin
        if (can_emit) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = STATUS_OK;
          out_data_d.read_value = '0;
          out_data_d.slot       = SlotW'(rem_q);
          unique case (kind_q)
            JOB_SET: begin
              we    = 1'b1;
              waddr = AddrW'(rem_q);
              wdata = wval_q;
            end
            JOB_GET: begin
              if (pointer_mode_i && (rdata_q == '0)) begin
                out_data_d.status = STATUS_EMPTY;
              end else begin
                out_data_d.read_value = ValueW'(rdata_q);
              end
            end
            JOB_FILL: begin
              out_data_d.slot   = '0;
              out_data_d.status = pointer_mode_i ? STATUS_WRONG_KIND : STATUS_OK;
            end
            default: begin
              out_data_d.status = STATUS_OK;
            end
          endcase
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      cnt_q       <= '0;
      bit_q       <= '0;
      kind_q      <= JOB_SET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    wval_q     <= wval_d;
    out_data_q <= out_data_d;
  end

  // Table memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[AddrW'(rem_q)];
    end
  end

endmodule

### hdl/shtab_checker.sv
`timescale 1ns / 1ps

module shtab_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input shtab_pkg::out_item_t          out_data_o
);
  import shtab_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Empty get returns no data
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_EMPTY) |-> out_data_o.read_value == '0)
    else $error("empty get carries data");

  // Rejected fill reports slot zero and no data
  a_wrong_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_WRONG_KIND)
      |-> (out_data_o.slot == '0) && (out_data_o.read_value == '0))
    else $error("wrong-kind result carries slot or data");

  // Status stays within the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_OK)
                 || (out_data_o.status == STATUS_WRONG_KIND)
                 || (out_data_o.status == STATUS_EMPTY))
    else $error("undefined status code");

endmodule

bind string_hashed_slot_table_core shtab_checker u_shtab_checker (.*);
